// ===== rtl/vcdg_pkg.sv =====
// ----------------------------------------------------------------------------
// vcdg_pkg
// shared constants, types and helpers of the volume gradient block
// ----------------------------------------------------------------------------
package vcdg_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_DEPTH  = 4096;

   localparam int VOXEL_BITS = 8;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int SLICE_BITS = 12;
   localparam int DIM_BITS   = 9;
   localparam int DEPTH_BITS = 13;
   localparam int GRAD_BITS  = 9;
   localparam int SQ_BITS    = 17;
   localparam int MAG_BITS   = 18;

   // one bank per slot and row parity
   localparam int BANK_ROWS      = MAX_HEIGHT / 2;
   localparam int BANK_DEPTH     = BANK_ROWS * MAX_WIDTH;
   localparam int BANK_ADDR_BITS = $clog2(BANK_DEPTH);
   localparam int BANK_COUNT     = 4;
   localparam int BANK_SEL_BITS  = 2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;
   localparam int RSP_DATA_BITS  = 112;
   localparam int RSP_PAD_BITS   = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEPTH  = 2'd2;

   localparam logic [MAG_BITS-1:0] MAG_ONES = '1;

   typedef struct packed {
      logic                  valid;
      logic                  start;
      logic                  interior;
      logic                  last;
      logic [COL_BITS-1:0]   col;
      logic [ROW_BITS-1:0]   row;
      logic [SLICE_BITS-1:0] slice;
   } tag_type;

   typedef struct packed {
      tag_type               tag;
      logic [VOXEL_BITS-1:0] voxel;
   } item_type;

   typedef struct packed {
      logic                      rd_en;
      logic                      wr_en;
      logic                      cur_slot;
      logic                      row_par;
      logic [BANK_ADDR_BITS-1:0] addr_c;
      logic [BANK_ADDR_BITS-1:0] addr_l;
      logic [BANK_ADDR_BITS-1:0] addr_r;
      logic [BANK_ADDR_BITS-1:0] addr_u;
      logic [BANK_ADDR_BITS-1:0] addr_d;
      logic [VOXEL_BITS-1:0]     wr_data;
   } mem_cmd_type;

   typedef struct packed {
      logic [VOXEL_BITS-1:0] left;
      logic [VOXEL_BITS-1:0] right;
      logic [VOXEL_BITS-1:0] up;
      logic [VOXEL_BITS-1:0] down;
      logic [VOXEL_BITS-1:0] centre;
   } nbr_type;

   typedef struct packed {
      logic [RSP_PAD_BITS-1:0]     pad;
      logic [MAG_BITS-1:0]         running_min;
      logic [MAG_BITS-1:0]         running_max;
      logic [SLICE_BITS-1:0]       out_slice;
      logic [ROW_BITS-1:0]         out_row;
      logic [COL_BITS-1:0]         out_column;
      logic [MAG_BITS-1:0]         magnitude_sq;
      logic signed [GRAD_BITS-1:0] grad_z;
      logic signed [GRAD_BITS-1:0] grad_y;
      logic signed [GRAD_BITS-1:0] grad_x;
   } result_type;

   // rows are split over two banks by parity
   function automatic logic [BANK_ADDR_BITS-1:0] bank_addr(
      input logic [ROW_BITS-1:0] row,
      input logic [COL_BITS-1:0] col
   );
      bank_addr = {row[ROW_BITS-1:1], col};
   endfunction

endpackage

// ===== rtl/vcdg_bank.sv =====
// ----------------------------------------------------------------------------
// vcdg_bank
// one slice bank: one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
module vcdg_bank
   import vcdg_pkg::*;
(
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic                      wr_en,
   input  logic [BANK_ADDR_BITS-1:0] wr_addr,
   input  logic [VOXEL_BITS-1:0]     wr_data,
   input  logic [BANK_ADDR_BITS-1:0] rd_addr_a,
   input  logic [BANK_ADDR_BITS-1:0] rd_addr_b,
   output logic [VOXEL_BITS-1:0]     rd_data_a,
   output logic [VOXEL_BITS-1:0]     rd_data_b
);

   logic [VOXEL_BITS-1:0] store_ff [BANK_DEPTH];
   logic [VOXEL_BITS-1:0] rd_a_ff;
   logic [VOXEL_BITS-1:0] rd_b_ff;

   // read-first: a read of the entry written in the same cycle sees old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= store_ff[rd_addr_a];
         rd_b_ff <= store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/vcdg_store.sv =====
// ----------------------------------------------------------------------------
// vcdg_store
// two-slice voxel store in four banks, neighbour fetch and selection
// ----------------------------------------------------------------------------
module vcdg_store
   import vcdg_pkg::*;
(
   input  logic        clock,
   input  mem_cmd_type mem_cmd,
   output nbr_type     nbr
);

   logic [VOXEL_BITS-1:0] rd_a [BANK_COUNT];
   logic [VOXEL_BITS-1:0] rd_b [BANK_COUNT];
   logic                  cur_ff;
   logic                  par_ff;

   genvar b;
   generate
      for (b = 0; b < BANK_COUNT; b++) begin : g_bank
         logic [BANK_SEL_BITS-1:0]  sel;
         logic                      is_cur;
         logic                      same_par;
         logic                      bank_we;
         logic [BANK_ADDR_BITS-1:0] addr_a;
         logic [BANK_ADDR_BITS-1:0] addr_b;

         assign sel      = BANK_SEL_BITS'(b);
         assign is_cur   = (sel[1] == mem_cmd.cur_slot);
         assign same_par = (sel[0] == mem_cmd.row_par);
         assign bank_we  = mem_cmd.wr_en && is_cur && same_par;
         // current slot: the voxel's own entry; previous slot: row or column pair
         assign addr_a   = is_cur ? mem_cmd.addr_c : (same_par ? mem_cmd.addr_l : mem_cmd.addr_u);
         assign addr_b   = same_par ? mem_cmd.addr_r : mem_cmd.addr_d;

         vcdg_bank u_bank (
            .clock     (clock),
            .rd_en     (mem_cmd.rd_en),
            .wr_en     (bank_we),
            .wr_addr   (mem_cmd.addr_c),
            .wr_data   (mem_cmd.wr_data),
            .rd_addr_a (addr_a),
            .rd_addr_b (addr_b),
            .rd_data_a (rd_a[b]),
            .rd_data_b (rd_b[b])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         cur_ff <= mem_cmd.cur_slot;
         par_ff <= mem_cmd.row_par;
      end
   end

   always_comb begin
      nbr.left   = rd_a[{~cur_ff, par_ff}];
      nbr.right  = rd_b[{~cur_ff, par_ff}];
      nbr.up     = rd_a[{~cur_ff, ~par_ff}];
      nbr.down   = rd_b[{~cur_ff, ~par_ff}];
      nbr.centre = rd_a[{cur_ff, par_ff}];
   end

endmodule

// ===== rtl/vcdg_scan.sv =====
// ----------------------------------------------------------------------------
// vcdg_scan
// dimension registers, raster position counters and store commands
// ----------------------------------------------------------------------------
module vcdg_scan
   import vcdg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [VOXEL_BITS-1:0]     req_tdata,
   input  logic                      req_tuser,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      advance,
   output mem_cmd_type               mem_cmd,
   output item_type                  item
);

   logic [DIM_BITS-1:0]   width_ff,  width_in;
   logic [DIM_BITS-1:0]   height_ff, height_in;
   logic [DEPTH_BITS-1:0] depth_ff,  depth_in;
   logic [COL_BITS-1:0]   col_ff,    col_in;
   logic [ROW_BITS-1:0]   row_ff,    row_in;
   logic [SLICE_BITS-1:0] slice_ff,  slice_in;
   item_type              item_ff,   item_in;

   logic                  accept;
   logic [COL_BITS-1:0]   cur_c;
   logic [ROW_BITS-1:0]   cur_r;
   logic [SLICE_BITS-1:0] cur_s;
   logic [DIM_BITS-1:0]   c_next;
   logic [DIM_BITS-1:0]   r_next;
   logic [DIM_BITS-1:0]   c_plus2;
   logic [DIM_BITS-1:0]   r_plus2;
   logic [DEPTH_BITS-1:0] s_next;
   logic                  interior;
   logic                  last;
   logic [DEPTH_BITS-1:0] clamp_w;
   logic [DEPTH_BITS-1:0] clamp_h;
   logic [DEPTH_BITS-1:0] clamp_d;

   function automatic logic [DEPTH_BITS-1:0] clamp_dim(
      input logic [DEPTH_BITS-1:0] v,
      input logic [DEPTH_BITS-1:0] hi
   );
      if (v == '0) begin
         clamp_dim = DEPTH_BITS'(1);
      end else if (v > hi) begin
         clamp_dim = hi;
      end else begin
         clamp_dim = v;
      end
   endfunction

   assign accept     = req_tvalid && advance;
   assign req_tready = advance;

   // dimension registers hold the clamped values
   always_comb begin
      clamp_w   = clamp_dim({4'b0, csr_wdata[DIM_BITS-1:0]}, DEPTH_BITS'(MAX_WIDTH));
      clamp_h   = clamp_dim({4'b0, csr_wdata[DIM_BITS-1:0]}, DEPTH_BITS'(MAX_HEIGHT));
      clamp_d   = clamp_dim(csr_wdata, DEPTH_BITS'(MAX_DEPTH));
      width_in  = width_ff;
      height_in = height_ff;
      depth_in  = depth_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_in  = clamp_w[DIM_BITS-1:0];
            CSR_HEIGHT: height_in = clamp_h[DIM_BITS-1:0];
            CSR_DEPTH:  depth_in  = clamp_d;
            default:    ;
         endcase
      end
   end

   always_comb begin
      cur_c   = req_tuser ? '0 : col_ff;
      cur_r   = req_tuser ? '0 : row_ff;
      cur_s   = req_tuser ? '0 : slice_ff;
      c_next  = {1'b0, cur_c} + DIM_BITS'(1);
      r_next  = {1'b0, cur_r} + DIM_BITS'(1);
      c_plus2 = {1'b0, cur_c} + DIM_BITS'(2);
      r_plus2 = {1'b0, cur_r} + DIM_BITS'(2);
      s_next  = {1'b0, cur_s} + DEPTH_BITS'(1);

      interior = (cur_s >= SLICE_BITS'(2)) && ({1'b0, cur_s} < depth_ff)
               && (cur_c != '0) && (c_next < width_ff)
               && (cur_r != '0) && (r_next < height_ff);
      last     = (c_plus2 == width_ff) && (r_plus2 == height_ff) && (s_next == depth_ff);

      col_in   = col_ff;
      row_in   = row_ff;
      slice_in = slice_ff;
      if (accept) begin
         if (c_next >= width_ff) begin
            col_in = '0;
            if (r_next >= height_ff) begin
               row_in   = '0;
               slice_in = (s_next >= depth_ff) ? '0 : s_next[SLICE_BITS-1:0];
            end else begin
               row_in   = r_next[ROW_BITS-1:0];
               slice_in = cur_s;
            end
         end else begin
            col_in   = c_next[COL_BITS-1:0];
            row_in   = cur_r;
            slice_in = cur_s;
         end
      end

      item_in                = item_ff;
      if (advance) begin
         item_in.tag.valid    = accept;
         item_in.tag.start    = req_tuser;
         item_in.tag.interior = interior;
         item_in.tag.last     = last;
         item_in.tag.col      = cur_c;
         item_in.tag.row      = cur_r;
         item_in.tag.slice    = cur_s - SLICE_BITS'(1);
         item_in.voxel        = req_tdata;
      end
   end

   always_comb begin
      mem_cmd.rd_en    = advance;
      mem_cmd.wr_en    = accept;
      mem_cmd.cur_slot = cur_s[0];
      mem_cmd.row_par  = cur_r[0];
      mem_cmd.addr_c   = bank_addr(cur_r, cur_c);
      mem_cmd.addr_l   = bank_addr(cur_r, cur_c - COL_BITS'(1));
      mem_cmd.addr_r   = bank_addr(cur_r, cur_c + COL_BITS'(1));
      mem_cmd.addr_u   = bank_addr(cur_r - ROW_BITS'(1), cur_c);
      mem_cmd.addr_d   = bank_addr(cur_r + ROW_BITS'(1), cur_c);
      mem_cmd.wr_data  = req_tdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff           <= DIM_BITS'(MAX_WIDTH);
         height_ff          <= DIM_BITS'(MAX_HEIGHT);
         depth_ff           <= DEPTH_BITS'(256);
         col_ff             <= '0;
         row_ff             <= '0;
         slice_ff           <= '0;
         item_ff.tag.valid  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         depth_ff  <= depth_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         slice_ff  <= slice_in;
         item_ff   <= item_in;
      end
   end

   assign item = item_ff;

endmodule

// ===== rtl/vcdg_grad.sv =====
// ----------------------------------------------------------------------------
// vcdg_grad
// differences, squares, magnitude, running min/max and result register
// ----------------------------------------------------------------------------
module vcdg_grad
   import vcdg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  item_type                 item,
   input  nbr_type                  nbr,
   output logic                     advance,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tlast
);

   typedef struct packed {
      tag_type                     tag;
      logic signed [GRAD_BITS-1:0] gx;
      logic signed [GRAD_BITS-1:0] gy;
      logic signed [GRAD_BITS-1:0] gz;
   } diff_type;

   typedef struct packed {
      diff_type             d;
      logic [SQ_BITS-1:0]   sqx;
      logic [SQ_BITS-1:0]   sqy;
      logic [SQ_BITS-1:0]   sqz;
   } square_type;

   typedef struct packed {
      diff_type             d;
      logic [MAG_BITS-1:0]  mag;
   } mag_type;

   diff_type             st2_ff, st2_in;
   square_type           st3_ff, st3_in;
   mag_type              st4_ff, st4_in;
   result_type           result_ff, result_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [MAG_BITS-1:0]  max_ff, max_in;
   logic [MAG_BITS-1:0]  min_ff, min_in;

   logic signed [2*GRAD_BITS-1:0] px, py, pz;
   logic [MAG_BITS:0]             sum;
   logic [MAG_BITS-1:0]           base_max, base_min, new_max, new_min;
   logic                          st4_result;

   assign st4_result = st4_ff.d.tag.valid && st4_ff.d.tag.interior;
   // stall only while a result waits and the next one is about to arrive
   assign advance    = !(rsp_valid_ff && !rsp_tready && st4_result);

   always_comb begin
      st2_in.tag = item.tag;
      st2_in.gx  = $signed({1'b0, nbr.right}) - $signed({1'b0, nbr.left});
      st2_in.gy  = $signed({1'b0, nbr.down}) - $signed({1'b0, nbr.up});
      st2_in.gz  = $signed({1'b0, item.voxel}) - $signed({1'b0, nbr.centre});

      px = $signed({{GRAD_BITS{st2_ff.gx[GRAD_BITS-1]}}, st2_ff.gx})
         * $signed({{GRAD_BITS{st2_ff.gx[GRAD_BITS-1]}}, st2_ff.gx});
      py = $signed({{GRAD_BITS{st2_ff.gy[GRAD_BITS-1]}}, st2_ff.gy})
         * $signed({{GRAD_BITS{st2_ff.gy[GRAD_BITS-1]}}, st2_ff.gy});
      pz = $signed({{GRAD_BITS{st2_ff.gz[GRAD_BITS-1]}}, st2_ff.gz})
         * $signed({{GRAD_BITS{st2_ff.gz[GRAD_BITS-1]}}, st2_ff.gz});
      st3_in.d   = st2_ff;
      st3_in.sqx = px[SQ_BITS-1:0];
      st3_in.sqy = py[SQ_BITS-1:0];
      st3_in.sqz = pz[SQ_BITS-1:0];

      sum = {2'b0, st3_ff.sqx} + {2'b0, st3_ff.sqy} + {2'b0, st3_ff.sqz};
      st4_in.d   = st3_ff.d;
      st4_in.mag = sum[MAG_BITS-1:0];
   end

   // running extremes restart with the first voxel of a volume
   always_comb begin
      base_max = st4_ff.d.tag.start ? '0 : max_ff;
      base_min = st4_ff.d.tag.start ? MAG_ONES : min_ff;
      new_max  = base_max;
      new_min  = base_min;
      if (st4_ff.d.tag.interior) begin
         if (st4_ff.mag > base_max) begin
            new_max = st4_ff.mag;
         end
         if (st4_ff.mag < base_min) begin
            new_min = st4_ff.mag;
         end
      end

      max_in       = max_ff;
      min_in       = min_ff;
      result_in    = result_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance && st4_ff.d.tag.valid) begin
         max_in = new_max;
         min_in = new_min;
      end
      if (advance && st4_result) begin
         rsp_valid_in           = 1'b1;
         rsp_last_in            = st4_ff.d.tag.last;
         result_in.pad          = '0;
         result_in.running_min  = new_min;
         result_in.running_max  = new_max;
         result_in.out_slice    = st4_ff.d.tag.slice;
         result_in.out_row      = st4_ff.d.tag.row;
         result_in.out_column   = st4_ff.d.tag.col;
         result_in.magnitude_sq = st4_ff.mag;
         result_in.grad_z       = st4_ff.d.gz;
         result_in.grad_y       = st4_ff.d.gy;
         result_in.grad_x       = st4_ff.d.gx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_ff.tag.valid   <= 1'b0;
         st3_ff.d.tag.valid <= 1'b0;
         st4_ff.d.tag.valid <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         max_ff             <= '0;
         min_ff             <= MAG_ONES;
      end else begin
         if (advance) begin
            st2_ff <= st2_in;
            st3_ff <= st3_in;
            st4_ff <= st4_in;
         end
         rsp_valid_ff <= rsp_valid_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff   <= result_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = result_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_extremes_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (result_ff.running_min <= result_ff.magnitude_sq
                        && result_ff.magnitude_sq <= result_ff.running_max))
      else $error("running extremes do not bound the magnitude");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !advance |-> (rsp_valid_ff && !rsp_tready && st4_result))
      else $error("pipeline stalled without a waiting result");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (advance && st4_result) |=> rsp_valid_ff)
      else $error("finished result not presented");

endmodule

// ===== rtl/volume_central_difference_gradient_top.sv =====
// ----------------------------------------------------------------------------
// volume_central_difference_gradient_top
// Streaming 3-D central-difference gradient of an 8-bit volume. Voxels enter
// in raster order (column, row, slice) at one voxel per clock; a transfer is
// taken every cycle unless a finished result is waiting on the result side and
// the next item at the end of the pipe is also a result, so req_tready follows
// rsp_tready combinationally. A result is presented on rsp_tvalid after its
// voxel transfer has passed the store read, difference, square and sum
// registers and then the extremes into the result register.
// The rate is set by the slice store: four single-write, dual-read banks
// (slot x row parity) that serve the four in-slice neighbours and the voxel two
// slices back in the same cycle the new voxel is written. The store needs no
// clearing pass after reset. Each interior voxel gives one result once the
// voxel one slice below it arrives; border voxels give none.
// ----------------------------------------------------------------------------
module volume_central_difference_gradient_top
   import vcdg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // voxel input
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [VOXEL_BITS-1:0]     req_tdata,   // [7:0] voxel_value
   input  logic                      req_tuser,   // [0] start_of_volume
   // gradient result
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [8:0] grad_x, [17:9] grad_y, [26:18] grad_z, [44:27] magnitude_sq,
   // [52:45] out_column, [60:53] out_row, [72:61] out_slice,
   // [90:73] running_max, [108:91] running_min, [111:109] zero
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                      rsp_tlast,   // last_interior
   // dimension registers: 0 width, 1 height, 2 depth
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic        advance;     // whole pipe moves on this cycle
   mem_cmd_type mem_cmd;     // store write and neighbour reads
   item_type    item;        // voxel position, flags and value beside the read data
   nbr_type     nbr;         // neighbours fetched from the store

   // position counters and store addressing
   vcdg_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .advance    (advance),
      .mem_cmd    (mem_cmd),
      .item       (item)
   );

   // two slices held in four banks
   vcdg_store u_store (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .nbr     (nbr)
   );

   // arithmetic and result hand-off
   vcdg_grad u_grad (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .nbr        (nbr),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
